// File: hw/rtl/nuf_pkg.sv
// Package for the NAL unit framer: request and result structs, configuration
// struct, register indexes and the fixed bytes of the framing.
// No dependencies.
`default_nettype none

package nuf_pkg;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 3;

  localparam logic [CfgIdxW-1:0] CfgPrefixMode   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgStartCodeLen = 1'd1;

  localparam logic [2:0] StartCodeLenReset = 3'd4;
  localparam logic [2:0] StartCodeLenShort = 3'd3;

  // Result sequencing: prefix (up to four bytes), escape byte, payload byte.
  localparam int unsigned MaxResults = 6;
  localparam int unsigned ResIdxW    = 3;

  localparam logic [ResIdxW-1:0] PrefixLenLong  = 3'd4;
  localparam logic [ResIdxW-1:0] PrefixLenShort = 3'd3;
  localparam logic [ResIdxW-1:0] PrefixLenNone  = 3'd0;

  // Fixed bytes.
  localparam logic [7:0] ByteZero    = 8'h00;
  localparam logic [7:0] ByteScEnd   = 8'h01;
  localparam logic [7:0] ByteEpb     = 8'h03;
  localparam logic [7:0] ByteEscMax  = 8'h03;

  // Trailing zero counter saturates at two.
  localparam logic [1:0] ZeroRunMax = 2'd2;

  typedef enum logic {
    PREFIX_ANNEXB = 1'b0,
    PREFIX_LENGTH = 1'b1
  } prefix_mode_e;

  typedef struct packed {
    prefix_mode_e prefix_mode;
    logic [2:0]   start_code_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        nal_first;
    logic [31:0] nal_size;
    logic        escape_enable;
    logic        unit_first;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [31:0] out_offset;
    logic        payload_start;
    logic        run_last;
  } out_item_t;

endpackage : nuf_pkg

`default_nettype wire

// File: hw/rtl/nuf_cfg_regs.sv
// Configuration registers of the NAL unit framer (prefix mode, start code length).
// Depends on nuf_pkg.
`default_nettype none

module nuf_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [nuf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [nuf_pkg::CfgDataW-1:0]  cfg_data_i,
  output nuf_pkg::cfg_t                      cfg_o
);

  nuf_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        nuf_pkg::CfgPrefixMode: begin
          cfg_d.prefix_mode = nuf_pkg::prefix_mode_e'(cfg_data_i[0]);
        end
        nuf_pkg::CfgStartCodeLen: begin
          cfg_d.start_code_len = cfg_data_i;
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prefix_mode    <= nuf_pkg::PREFIX_ANNEXB;
      cfg_q.start_code_len <= nuf_pkg::StartCodeLenReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule : nuf_cfg_regs

`default_nettype wire

// File: hw/rtl/nuf_seq.sv
// Holding register and result sequencer: expands one request into prefix,
// escape and payload bytes, and keeps the zero run and output offset.
// Depends on nuf_pkg.
`default_nettype none

module nuf_seq (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire nuf_pkg::cfg_t cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire nuf_pkg::in_item_t in_req_i,
  input  wire logic        emit_ready_i,
  output logic             emit_valid_o,
  output nuf_pkg::out_item_t emit_res_o
);

  nuf_pkg::in_item_t              cur_q;
  logic                           cur_valid_q;
  logic [nuf_pkg::ResIdxW-1:0]    idx_q, idx_d;
  logic [1:0]                     zero_run_q, zero_run_d;
  logic [31:0]                    pos_q, pos_d;

  logic [nuf_pkg::ResIdxW-1:0]    prefix_len;
  logic [nuf_pkg::ResIdxW-1:0]    n_total;
  logic [1:0]                     zr_base;
  logic                           esc_hit;
  logic                           last;
  logic                           emit;
  logic [31:0]                    pos_eff;
  logic [7:0]                     len_byte;
  logic [7:0]                     prefix_byte;

  // The zero run restarts at every NAL start, before the escape check.
  assign zr_base = cur_q.nal_first ? 2'd0 : zero_run_q;
  assign esc_hit = cur_q.escape_enable && (zr_base == nuf_pkg::ZeroRunMax) &&
                   (cur_q.data_byte <= nuf_pkg::ByteEscMax);

  always_comb begin
    if (!cur_q.nal_first) begin
      prefix_len = nuf_pkg::PrefixLenNone;
    end else if (cfg_i.prefix_mode == nuf_pkg::PREFIX_ANNEXB &&
                 cfg_i.start_code_len == nuf_pkg::StartCodeLenShort) begin
      prefix_len = nuf_pkg::PrefixLenShort;
    end else begin
      prefix_len = nuf_pkg::PrefixLenLong;
    end
  end

  assign n_total = prefix_len + nuf_pkg::ResIdxW'(esc_hit) + nuf_pkg::ResIdxW'(1);
  assign last    = (idx_q == n_total - nuf_pkg::ResIdxW'(1));
  assign emit    = cur_valid_q && emit_ready_i;

  // The access unit offset is cleared just before the first result of a request with unit_first set.
  assign pos_eff = (idx_q == '0 && cur_q.unit_first) ? 32'd0 : pos_q;

  always_comb begin
    case (idx_q[1:0])
      2'd0:    len_byte = cur_q.nal_size[31:24];
      2'd1:    len_byte = cur_q.nal_size[23:16];
      2'd2:    len_byte = cur_q.nal_size[15:8];
      default: len_byte = cur_q.nal_size[7:0];
    endcase
  end

  always_comb begin
    if (cfg_i.prefix_mode == nuf_pkg::PREFIX_LENGTH) begin
      prefix_byte = len_byte;
    end else if (idx_q == prefix_len - nuf_pkg::ResIdxW'(1)) begin
      prefix_byte = nuf_pkg::ByteScEnd;
    end else begin
      prefix_byte = nuf_pkg::ByteZero;
    end
  end

  always_comb begin
    emit_res_o.out_offset    = pos_eff;
    emit_res_o.run_last      = last;
    emit_res_o.payload_start = 1'b0;
    if (idx_q < prefix_len) begin
      emit_res_o.out_byte = prefix_byte;
    end else if (esc_hit && idx_q == prefix_len) begin
      emit_res_o.out_byte = nuf_pkg::ByteEpb;
    end else begin
      emit_res_o.out_byte      = cur_q.data_byte;
      emit_res_o.payload_start = cur_q.nal_first;
    end
  end

  assign emit_valid_o = cur_valid_q;
  assign in_ready_o   = !cur_valid_q || (emit && last);

  always_comb begin
    idx_d      = idx_q;
    pos_d      = pos_q;
    zero_run_d = zero_run_q;
    if (emit) begin
      pos_d = pos_eff + 32'd1;
      if (last) begin
        idx_d = '0;
        if (cur_q.data_byte != nuf_pkg::ByteZero) begin
          zero_run_d = 2'd0;
        end else if (esc_hit) begin
          zero_run_d = 2'd1;
        end else if (zr_base < nuf_pkg::ZeroRunMax) begin
          zero_run_d = zr_base + 2'd1;
        end else begin
          zero_run_d = nuf_pkg::ZeroRunMax;
        end
      end else begin
        idx_d = idx_q + nuf_pkg::ResIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      zero_run_q  <= 2'd0;
      pos_q       <= 32'd0;
    end else begin
      idx_q      <= idx_d;
      zero_run_q <= zero_run_d;
      pos_q      <= pos_d;
      if (in_valid_i && in_ready_o) begin
        cur_valid_q <= 1'b1;
      end else if (emit && last) begin
        cur_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cur_q <= in_req_i;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= nuf_pkg::ResIdxW'(nuf_pkg::MaxResults - 1))
    else $error("result index out of range");

  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cur_valid_q |-> idx_q == '0)
    else $error("result index not at zero while empty");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !last) |=> (cur_valid_q && idx_q == $past(idx_q) + nuf_pkg::ResIdxW'(1)))
    else $error("sequencer lost its request mid-run");

  a_zero_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_run_q <= nuf_pkg::ZeroRunMax)
    else $error("zero run above saturation");

endmodule : nuf_seq

`default_nettype wire

// File: hw/rtl/nuf_out_reg.sv
// Result register of the NAL unit framer: holds one result until taken.
// Depends on nuf_pkg.
`default_nettype none

module nuf_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_valid_i,
  output logic                load_ready_o,
  input  wire nuf_pkg::out_item_t load_res_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output nuf_pkg::out_item_t  out_res_o
);

  logic               valid_q;
  nuf_pkg::out_item_t res_q;

  // The register can take a new result when empty or when its result leaves now.
  assign load_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ready_o && load_valid_i) begin
      res_q <= load_res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule : nuf_out_reg

`default_nettype wire

// File: hw/rtl/nal_unit_framer_with_escaping.sv
// Top level of the NAL unit framer with emulation prevention.
// Depends on nuf_pkg, nuf_cfg_regs, nuf_seq and nuf_out_reg.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_ready_o    in_req_i  (nuf_pkg::in_item_t)
//   out       output     out_valid_o / out_ready_i  out_res_o (nuf_pkg::out_item_t)
//   cfg       input      cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// Each request occupies the sequencer for its prefix (none without nal_first, 3
// or 4 bytes with it), an emulation prevention byte when one is inserted and its
// payload byte; the single result register moves one byte per cycle unless the
// output stalls. A one-byte request is accepted every cycle unless the output
// stalls. The first result goes out through the holding and result registers.
// Reset is asynchronous and active low; it clears the configuration to Annex B
// with four byte start codes, the zero run and the output offset.
// A stall on the output holds the sequencer; new requests are taken as soon as
// the current one hands over its last byte.
`default_nettype none

module nal_unit_framer_with_escaping (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input requests, one NAL byte each.
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire nuf_pkg::in_item_t             in_req_i,
  // Framed output bytes.
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output nuf_pkg::out_item_t                 out_res_o,
  // Configuration writes.
  input  wire logic                          cfg_we_i,
  input  wire logic [nuf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [nuf_pkg::CfgDataW-1:0]  cfg_data_i
);

  nuf_pkg::cfg_t      cfg;
  logic               emit_valid;
  logic               emit_ready;
  nuf_pkg::out_item_t emit_res;

  // Configuration registers; the user must write them only while the block is idle, as the block does not enforce it.
  nuf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The sequencer holds the current request and produces its prefix, the optional
  // escape byte and the payload byte, one per cycle unless the output stalls.
  nuf_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .emit_ready_i (emit_ready),
    .emit_valid_o (emit_valid),
    .emit_res_o   (emit_res)
  );

  // The result register separates the sequencer from the downstream consumer.
  nuf_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (emit_valid),
    .load_ready_o (emit_ready),
    .load_res_i   (emit_res),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_res_o    (out_res_o)
  );

endmodule : nal_unit_framer_with_escaping

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for nal_unit_framer_with_escaping: directed and random NAL streams
// against a built-in framing predictor, with random idling on both sides.
// Depends on nuf_pkg and the framer RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RunLimit   = 200_000;
  localparam int unsigned MaxReports = 10;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  nuf_pkg::in_item_t            in_req = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b1;
  nuf_pkg::out_item_t           out_res;
  logic                         cfg_we = 1'b0;
  logic [nuf_pkg::CfgIdxW-1:0]  cfg_idx = nuf_pkg::CfgPrefixMode;
  logic [nuf_pkg::CfgDataW-1:0] cfg_data = '0;

  // Bytes the framer is expected to emit, oldest first.
  nuf_pkg::out_item_t framed_q[$];
  int unsigned        mismatch_cnt = 0;

  // Predictor copy of the framer's registers and state.
  nuf_pkg::prefix_mode_e mode_r = nuf_pkg::PREFIX_ANNEXB;
  logic [2:0]            sc_len_r = nuf_pkg::StartCodeLenReset;
  logic [1:0]            zero_run_r = '0;
  logic [31:0]           offset_r = '0;

  // Sender burst bookkeeping.
  int unsigned   burst_left = 0;

  nal_unit_framer_with_escaping dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: a run that hangs ends here as a failure.
  initial begin
    repeat (RunLimit) @(posedge clk_i);
    $display("tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Queues one emitted byte and advances the running offset, which wraps at 2^32.
  function automatic void emit_byte(input logic [7:0] b, input logic pstart);
    nuf_pkg::out_item_t r;
    r.out_byte      = b;
    r.out_offset    = offset_r;
    r.payload_start = pstart;
    r.run_last      = 1'b0;
    framed_q.push_back(r);
    offset_r = offset_r + 32'd1;
  endfunction

  // Works out every byte one accepted request produces: an optional prefix, an
  // optional emulation prevention byte, then the payload byte itself.
  function automatic void frame_request(input nuf_pkg::in_item_t it);
    nuf_pkg::out_item_t tail;
    if (it.unit_first) begin
      offset_r = '0;
    end
    if (it.nal_first) begin
      zero_run_r = '0;
      if (mode_r == nuf_pkg::PREFIX_ANNEXB) begin
        // Anything but the short length gives the four byte start code.
        if (sc_len_r != nuf_pkg::StartCodeLenShort) begin
          emit_byte(nuf_pkg::ByteZero, 1'b0);
        end
        emit_byte(nuf_pkg::ByteZero, 1'b0);
        emit_byte(nuf_pkg::ByteZero, 1'b0);
        emit_byte(nuf_pkg::ByteScEnd, 1'b0);
      end else begin
        emit_byte(it.nal_size[31:24], 1'b0);
        emit_byte(it.nal_size[23:16], 1'b0);
        emit_byte(it.nal_size[15:8], 1'b0);
        emit_byte(it.nal_size[7:0], 1'b0);
      end
    end
    // The zero run counts payload bytes only, whether or not they are escaped.
    if (it.escape_enable && zero_run_r == nuf_pkg::ZeroRunMax &&
        it.data_byte <= nuf_pkg::ByteEscMax) begin
      emit_byte(nuf_pkg::ByteEpb, 1'b0);
      zero_run_r = '0;
    end
    if (it.data_byte == nuf_pkg::ByteZero) begin
      if (zero_run_r < nuf_pkg::ZeroRunMax) begin
        zero_run_r = zero_run_r + 2'd1;
      end
    end else begin
      zero_run_r = '0;
    end
    emit_byte(it.data_byte, it.nal_first);
    tail = framed_q.pop_back();
    tail.run_last = 1'b1;
    framed_q.push_back(tail);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted output byte is compared with the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    nuf_pkg::out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (framed_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports) begin
          $display("unexpected byte %02h at offset %0d", out_res.out_byte, out_res.out_offset);
        end
      end else begin
        want = framed_q.pop_front();
        if (out_res.out_byte != want.out_byte || out_res.out_offset != want.out_offset ||
            out_res.payload_start != want.payload_start ||
            out_res.run_last != want.run_last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports) begin
            $display("mismatch: expected byte %02h offset %0d start %0b last %0b,",
                     want.out_byte, want.out_offset, want.payload_start, want.run_last);
            $display("          got byte %02h offset %0d start %0b last %0b",
                     out_res.out_byte, out_res.out_offset, out_res.payload_start,
                     out_res.run_last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stalls follow a mode that is redrawn at random during the run: never
  // stalling, occasional short stalls, or long frequent ones.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    static int unsigned stall_left = 0;
    static int unsigned stall_mode = 0;
    static int unsigned phase_cyc = 0;
    logic nxt_ready;
    nxt_ready = 1'b1;
    phase_cyc++;
    if (phase_cyc % 50 == 0) begin
      stall_mode = $urandom_range(0, 2);
    end
    if (stall_left != 0) begin
      nxt_ready = 1'b0;
      stall_left--;
    end else if (stall_mode == 1 && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 1);
      nxt_ready  = 1'b0;
    end else if (stall_mode == 2 && $urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(0, 5);
      nxt_ready  = 1'b0;
    end
    out_ready = rst_ni ? nxt_ready : 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  function automatic nuf_pkg::in_item_t mk_req(input logic [7:0] b, input logic first,
                                               input logic [31:0] len, input logic esc,
                                               input logic unit);
    nuf_pkg::in_item_t it;
    it.data_byte     = b;
    it.nal_first     = first;
    it.nal_size      = len;
    it.escape_enable = esc;
    it.unit_first    = unit;
    return it;
  endfunction

  // Sends one request. Called right after a falling edge; returns right after
  // the falling edge that follows acceptance, with valid still high so that a
  // burst continues without a bubble. Between bursts valid usually drops for a gap.
  task automatic send_req(input nuf_pkg::in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_req   = it;
    in_valid = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!in_ready);
    frame_request(it);
    @(negedge clk_i);
  endtask

  // Lowers valid and waits until every expected byte has come out.
  task automatic drain();
    in_valid   = 1'b0;
    burst_left = 0;
    wait (framed_q.size() == 0);
    repeat (3) @(negedge clk_i);
  endtask

  // Register writes happen only once the framer has gone idle.
  task automatic write_reg(input logic [nuf_pkg::CfgIdxW-1:0] idx,
                           input logic [nuf_pkg::CfgDataW-1:0] val);
    drain();
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(posedge clk_i);
    if (idx == nuf_pkg::CfgPrefixMode) begin
      mode_r = nuf_pkg::prefix_mode_e'(val[0]);
    end else begin
      sc_len_r = val;
    end
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Payload bytes lean heavily on zeros and small values so that escaping
  // triggers often.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return nuf_pkg::ByteZero;
    end else if (r < 7) begin
      return 8'($urandom_range(1, 3));
    end else if (r == 7) begin
      return 8'($urandom_range(4, 5));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_length(input int unsigned bytes);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'(bytes);
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Start codes of the reset length and the escape rules.
  task automatic test_escaping();
    // Bytes ahead of any NAL start are copied with no prefix.
    send_req(mk_req(8'h00, 1'b0, '0, 1'b1, 1'b0));
    // A new access unit without a NAL start only clears the offset.
    send_req(mk_req(8'h55, 1'b0, '0, 1'b1, 1'b1));
    send_req(mk_req(8'h00, 1'b1, '0, 1'b1, 1'b1));
    send_req(mk_req(8'h00, 1'b0, '0, 1'b1, 1'b0));
    // Third zero in a row gets an escape byte ahead of it.
    send_req(mk_req(8'h00, 1'b0, '0, 1'b1, 1'b0));
    send_req(mk_req(8'h00, 1'b0, '0, 1'b1, 1'b0));
    send_req(mk_req(8'h03, 1'b0, '0, 1'b1, 1'b0));
    // 0x04 after two zeros needs no escape.
    send_req(mk_req(8'h00, 1'b0, '0, 1'b1, 1'b0));
    send_req(mk_req(8'h00, 1'b0, '0, 1'b1, 1'b0));
    send_req(mk_req(8'h04, 1'b0, '0, 1'b1, 1'b0));
    // Escaping switched off for three bytes inside the NAL.
    send_req(mk_req(8'h00, 1'b0, '0, 1'b0, 1'b0));
    send_req(mk_req(8'h00, 1'b0, '0, 1'b0, 1'b0));
    send_req(mk_req(8'h01, 1'b0, '0, 1'b0, 1'b0));
    // A NAL start clears the zero run, so no escape here.
    send_req(mk_req(8'h00, 1'b0, '0, 1'b1, 1'b0));
    send_req(mk_req(8'h00, 1'b0, '0, 1'b1, 1'b0));
    send_req(mk_req(8'h02, 1'b1, '1, 1'b1, 1'b0));
    send_req(mk_req(8'hFF, 1'b0, '1, 1'b1, 1'b0));
    drain();
  endtask

  // Short and long start codes, odd length codes, and length prefixes.
  task automatic test_prefix_forms();
    write_reg(nuf_pkg::CfgStartCodeLen, nuf_pkg::StartCodeLenShort);
    send_req(mk_req(8'h00, 1'b1, '0, 1'b1, 1'b1));
    write_reg(nuf_pkg::CfgStartCodeLen, 3'd0);
    send_req(mk_req(8'h80, 1'b1, '0, 1'b0, 1'b0));
    write_reg(nuf_pkg::CfgStartCodeLen, 3'd7);
    send_req(mk_req(8'h7F, 1'b1, '0, 1'b1, 1'b0));
    // Only the low bit of the mode register counts.
    write_reg(nuf_pkg::CfgPrefixMode, 3'b111);
    // Prefix zeros never count toward the zero run.
    send_req(mk_req(8'h01, 1'b1, 32'h0000_0000, 1'b1, 1'b1));
    send_req(mk_req(8'h00, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_req(mk_req(8'hA5, 1'b1, 32'h5AA5_C33C, 1'b0, 1'b0));
    write_reg(nuf_pkg::CfgPrefixMode, 3'b110);
    send_req(mk_req(8'h00, 1'b1, '1, 1'b1, 1'b0));
    drain();
  endtask

  // Random phases, each with its own register setting; most traffic is whole
  // NAL units, the rest stray bytes and bare access unit marks.
  task automatic test_random_streams();
    int unsigned phase_items;
    int unsigned nal_bytes;
    int unsigned pick;
    logic        esc;
    logic        unit;
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(nuf_pkg::CfgPrefixMode, 3'($urandom_range(0, 7)));
      write_reg(nuf_pkg::CfgStartCodeLen,
                ($urandom_range(0, 1) == 0) ? nuf_pkg::StartCodeLenShort
                                            : 3'($urandom_range(0, 7)));
      phase_items = 0;
      while (phase_items < 20) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          nal_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16)
                                                  : $urandom_range(1, 8);
          esc  = ($urandom_range(0, 4) != 0);
          unit = ($urandom_range(0, 2) == 0);
          for (int i = 0; i < nal_bytes; i++) begin
            // Now and then a single byte flips its escape flag.
            send_req(mk_req(pick_byte(), i == 0, pick_length(nal_bytes),
                            ($urandom_range(0, 9) == 0) ? !esc : esc, unit && i == 0));
          end
          phase_items += nal_bytes;
        end else begin
          send_req(mk_req(pick_byte(), 1'b0, $urandom(), 1'($urandom_range(0, 1)),
                          pick == 9));
          phase_items++;
        end
      end
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_escaping();
    test_prefix_forms();
    test_random_streams();

    wait (framed_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && framed_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule : tb

`default_nettype wire

// File: filelist.f
hw/rtl/nuf_pkg.sv
hw/rtl/nuf_cfg_regs.sv
hw/rtl/nuf_seq.sv
hw/rtl/nuf_out_reg.sv
hw/rtl/nal_unit_framer_with_escaping.sv
bench/tb.sv
